// ===== hw/rtl/wbrm_pkg.sv =====
// Types and fixed constants for the windowed byte rate meter.
// No dependencies; imported by windowed_byte_rate_meter_unit.
`timescale 1ns / 1ps
`default_nettype none

package wbrm_pkg;

  localparam int unsigned CNT_W     = 32;  // byte counter width
  localparam int unsigned TIME_W    = 24;  // tick time width, 1/65536 s units
  localparam int unsigned RATE_W    = 32;  // rate width, also quotient bits
  localparam int unsigned FRAC_W    = 16;  // fraction bits of the time unit
  localparam int unsigned DIV_CNT_W = 5;   // counts RATE_W divide steps

  typedef struct packed {
    logic [CNT_W-1:0]  sent_total;
    logic [CNT_W-1:0]  received_total;
    logic [TIME_W-1:0] tick_time;
  } rate_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] sent_rate;
    logic [RATE_W-1:0] received_rate;
    logic              zero_time;
  } rate_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } wbrm_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/windowed_byte_rate_meter_unit.sv =====
// Sliding-window byte rate meter: ring memory, running sums, bit-serial dividers.
// Depends on wbrm_pkg (word structs, state enum, widths).
//
// Usage: each input word carries the cumulative sent/received byte counters and
// the elapsed tick time. in_stall_o is low only while the block is idle; a word
// is taken when in_valid_i is high and in_stall_o is low. One result word per
// input word leaves on the out channel (out_valid_o / out_stall_i).
// From acceptance to out_valid_o a word passes the memory read, the
// running-sum update and the overflow/zero check, then the steps of a
// restoring divider that yields one quotient bit per cycle for both rates,
// and the load of the output register. The block takes no new word until
// it has returned to idle; the divider loop dominates the time per word.
// A finished result sits in the output register while the next word is taken.
// If the receiver stalls, the result holds; a later result waits in the done
// state until the output register frees up.
// Reset clears the ring (per-slot valid bits, an invalid slot reads as zero),
// the running sums, the previous counters and the write slot.
`timescale 1ns / 1ps
`default_nettype none

module windowed_byte_rate_meter_unit #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wbrm_pkg::rate_in_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wbrm_pkg::rate_out_t out_word_o
);

  import wbrm_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = CNT_W + SLOT_W;
  localparam int unsigned TSUM_W = TIME_W + SLOT_W;
  localparam int unsigned ENT_W  = 2 * CNT_W + TIME_W;
  localparam int unsigned CMP_W  = (SUM_W > TSUM_W + FRAC_W) ? SUM_W : TSUM_W + FRAC_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(RATE_W - 1);

  wbrm_state_e state_q, state_d;

  // ring memory, one entry holds {sent diff, received diff, tick time}
  logic [ENT_W-1:0]        ring_mem [WINDOW_DEPTH];
  logic [ENT_W-1:0]        rd_data_q;
  logic                    rd_valid_q;
  logic [WINDOW_DEPTH-1:0] valid_q;

  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  prev_sent_q, prev_recv_q;
  rate_in_t          in_q;

  logic [SUM_W-1:0]  sum_q [2];
  logic [SUM_W-1:0]  sum_d [2];
  logic [TSUM_W-1:0] tsum_q, tsum_d;

  logic [TSUM_W-1:0] rem_q [2];
  logic [RATE_W-1:0] quo_q [2];
  logic [TSUM_W-1:0] rem_step [2];
  logic [RATE_W-1:0] quo_step [2];
  logic [1:0]        ovf_q;
  logic              zero_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic      out_valid_q;
  rate_out_t out_q;

  logic accept, out_free, load_out;
  logic do_read, do_update, do_check, do_div;

  logic [CNT_W-1:0]  old_sent, old_recv, diff_sent, diff_recv;
  logic [TIME_W-1:0] old_time;
  logic [ENT_W-1:0]  new_entry;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_CHECK;
      ST_CHECK:  state_d = ST_DIV;
      ST_DIV:    if (cnt_q == LAST_STEP) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    do_read    = 1'b0;
    do_update  = 1'b0;
    do_check   = 1'b0;
    do_div     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_READ:   do_read    = 1'b1;
      ST_UPDATE: do_update  = 1'b1;
      ST_CHECK:  do_check   = 1'b1;
      ST_DIV:    do_div     = 1'b1;
      ST_DONE:   load_out   = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // memory port: registered read of the slot about to be overwritten
  always_ff @(posedge clk_i) begin
    if (do_read) begin
      rd_data_q <= ring_mem[slot_q];
    end
    if (do_update) begin
      ring_mem[slot_q] <= new_entry;
    end
  end

  // a slot never written since reset reads as zero
  assign old_sent  = rd_valid_q ? rd_data_q[ENT_W-1 -: CNT_W] : '0;
  assign old_recv  = rd_valid_q ? rd_data_q[TIME_W +: CNT_W] : '0;
  assign old_time  = rd_valid_q ? rd_data_q[TIME_W-1:0] : '0;
  assign diff_sent = in_q.sent_total - prev_sent_q;
  assign diff_recv = in_q.received_total - prev_recv_q;
  assign new_entry = {diff_sent, diff_recv, in_q.tick_time};

  // running sums replace the old slot contents with the new ones
  always_comb begin
    sum_d[0] = SUM_W'(sum_q[0] + SUM_W'(diff_sent) - SUM_W'(old_sent));
    sum_d[1] = SUM_W'(sum_q[1] + SUM_W'(diff_recv) - SUM_W'(old_recv));
    tsum_d   = TSUM_W'(tsum_q + TSUM_W'(in_q.tick_time) - TSUM_W'(old_time));
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      slot_q      <= '0;
      prev_sent_q <= '0;
      prev_recv_q <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      tsum_q      <= '0;
    end else begin
      if (do_read) begin
        rd_valid_q <= valid_q[slot_q];
      end
      if (do_update) begin
        valid_q[slot_q] <= 1'b1;
        slot_q          <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
        prev_sent_q     <= in_q.sent_total;
        prev_recv_q     <= in_q.received_total;
        sum_q[0]        <= sum_d[0];
        sum_q[1]        <= sum_d[1];
        tsum_q          <= tsum_d;
      end
    end
  end

  // restoring divide step, one quotient bit per cycle per lane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [TSUM_W:0] rem_sh;
      logic            take;
      rem_sh      = {rem_q[l], quo_q[l][RATE_W-1]};
      take        = (rem_sh >= {1'b0, tsum_q});
      rem_step[l] = take ? TSUM_W'(rem_sh - {1'b0, tsum_q}) : rem_sh[TSUM_W-1:0];
      quo_step[l] = {quo_q[l][RATE_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (do_check) begin
      cnt_q <= '0;
    end else if (do_div) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // quotient of (sum << 16) / tsum: upper bits seed the remainder, the low
  // word shifts out as the quotient shifts in
  always_ff @(posedge clk_i) begin
    if (do_check) begin
      zero_q <= (tsum_q == '0);
      for (int l = 0; l < 2; l++) begin
        ovf_q[l] <= (CMP_W'(sum_q[l]) >= CMP_W'({tsum_q, {FRAC_W{1'b0}}}));
        rem_q[l] <= TSUM_W'(sum_q[l] >> FRAC_W);
        quo_q[l] <= {sum_q[l][FRAC_W-1:0], {(RATE_W - FRAC_W){1'b0}}};
      end
    end else if (do_div) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_step[l];
        quo_q[l] <= quo_step[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.zero_time     <= zero_q;
      out_q.sent_rate     <= zero_q ? '0 : (ovf_q[0] ? '1 : quo_q[0]);
      out_q.received_rate <= zero_q ? '0 : (ovf_q[1] ? '1 : quo_q[1]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
